[rtl/core/htsd_pkg.sv]
package htsd_pkg;

	localparam int MAX_NODES   = 512;
	localparam int STACK_DEPTH = 256;

	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int STK_IDX_W = $clog2(STACK_DEPTH);
	localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
	localparam int PEND_W    = NODE_W + 1;
	localparam int BYTE_W    = 8;

	localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

	localparam logic KIND_SYMBOL = 1'b0;
	localparam logic KIND_ERROR  = 1'b1;

	typedef struct packed {
		logic              leaf;
		logic [BYTE_W-1:0] sym;
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
	} node_entry_t;

	typedef struct packed {
		logic              alloc_en;
		logic              alloc_leaf;
		logic [NODE_W-1:0] alloc_node;
		logic              att_en;
		logic              att_right;
		logic [NODE_W-1:0] att_parent;
		logic              sym_en;
		logic [NODE_W-1:0] sym_node;
		logic [BYTE_W-1:0] sym_val;
	} nt_wr_t;

	typedef struct packed {
		logic                   en;
		logic [1:0][NODE_W-1:0] addr;
	} nt_rd_t;

	typedef struct packed {
		logic              clear;
		logic              alloc;
		logic              leaf;
		logic [NODE_W-1:0] node;
	} stk_op_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic              att_en;
		logic              att_right;
		logic [NODE_W-1:0] att_parent;
	} stk_st_t;

endpackage

[rtl/core/htsd_if.sv]
interface htsd_in_if;
	logic                        valid;
	logic                        ready;
	logic [htsd_pkg::BYTE_W-1:0] in_byte;
	logic                        first_of_file;

	modport source(output valid, in_byte, first_of_file, input ready);
	modport sink(input valid, in_byte, first_of_file, output ready);
endinterface

interface htsd_out_if;
	logic                        valid;
	logic                        ready;
	logic [htsd_pkg::BYTE_W-1:0] symbol;
	logic                        kind;

	modport source(output valid, symbol, kind, input ready);
	modport sink(input valid, symbol, kind, output ready);
endinterface

[rtl/core/htsd_ram.sv]
module htsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write-first: a read of the entry being written returns the new data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

[rtl/core/htsd_node_table.sv]
module htsd_node_table (
	input  logic                       clk,
	input  htsd_pkg::nt_wr_t           wr,
	input  htsd_pkg::nt_rd_t           rd,
	output htsd_pkg::node_entry_t [1:0] ent,
	output htsd_pkg::node_entry_t      root
);

	htsd_pkg::node_entry_t root_q;

	// two copies of every field memory, one per read port
	for (genvar g = 0; g < 2; g++) begin : g_port
		htsd_ram #(.WIDTH(1), .DEPTH(htsd_pkg::MAX_NODES)) u_leaf (
			.clk   (clk),
			.we    (wr.alloc_en),
			.waddr (wr.alloc_node),
			.wdata (wr.alloc_leaf),
			.re    (rd.en),
			.raddr (rd.addr[g]),
			.rdata (ent[g].leaf)
		);

		htsd_ram #(.WIDTH(htsd_pkg::BYTE_W), .DEPTH(htsd_pkg::MAX_NODES)) u_sym (
			.clk   (clk),
			.we    (wr.sym_en),
			.waddr (wr.sym_node),
			.wdata (wr.sym_val),
			.re    (rd.en),
			.raddr (rd.addr[g]),
			.rdata (ent[g].sym)
		);

		htsd_ram #(.WIDTH(htsd_pkg::NODE_W), .DEPTH(htsd_pkg::MAX_NODES)) u_left (
			.clk   (clk),
			.we    (wr.att_en && !wr.att_right),
			.waddr (wr.att_parent),
			.wdata (wr.alloc_node),
			.re    (rd.en),
			.raddr (rd.addr[g]),
			.rdata (ent[g].left)
		);

		htsd_ram #(.WIDTH(htsd_pkg::NODE_W), .DEPTH(htsd_pkg::MAX_NODES)) u_right (
			.clk   (clk),
			.we    (wr.att_en && wr.att_right),
			.waddr (wr.att_parent),
			.wdata (wr.alloc_node),
			.re    (rd.en),
			.raddr (rd.addr[g]),
			.rdata (ent[g].right)
		);
	end

	// register copy of the root entry
	always_ff @(posedge clk) begin
		if (wr.alloc_en && (wr.alloc_node == '0)) begin
			root_q <= '{leaf: wr.alloc_leaf, sym: '0, left: '0, right: '0};
		end
		if (wr.att_en && (wr.att_parent == '0)) begin
			if (wr.att_right) begin
				root_q.right <= wr.alloc_node;
			end else begin
				root_q.left <= wr.alloc_node;
			end
		end
		if (wr.sym_en && (wr.sym_node == '0)) begin
			root_q.sym <= wr.sym_val;
		end
	end

	assign root = root_q;

endmodule

[rtl/core/htsd_pend_stack.sv]
module htsd_pend_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  htsd_pkg::stk_op_t op,
	output htsd_pkg::stk_st_t st
);

	logic [htsd_pkg::LVL_W-1:0]  level_q;
	logic [htsd_pkg::LVL_W-1:0]  lvl_eff;
	logic [htsd_pkg::LVL_W-1:0]  lvl_mid;
	logic [htsd_pkg::LVL_W-1:0]  lvl_eff_dec;
	logic [htsd_pkg::LVL_W-1:0]  lvl_mid_dec;
	logic [htsd_pkg::PEND_W-1:0] top_q;
	logic [htsd_pkg::PEND_W-1:0] top_eff;
	logic [htsd_pkg::PEND_W-1:0] top_set;
	logic [htsd_pkg::PEND_W-1:0] top_next;
	logic [htsd_pkg::PEND_W-1:0] rd_data;
	logic                        reload_s1;
	logic                        attaching;
	logic                        popped;
	logic                        push;
	logic                        wr_en;
	logic                        rd_en;

	// top of stack lives in a register, entries below it in memory
	assign top_eff     = reload_s1 ? rd_data : top_q;
	assign top_set     = top_eff | htsd_pkg::PEND_W'(1);
	assign lvl_eff     = op.clear ? '0 : level_q;
	assign attaching   = op.alloc && (lvl_eff != '0);
	assign popped      = attaching && top_eff[0];
	assign push        = op.alloc && !op.leaf;
	assign lvl_mid     = popped ? (lvl_eff - htsd_pkg::LVL_W'(1)) : lvl_eff;
	assign lvl_eff_dec = lvl_eff - htsd_pkg::LVL_W'(1);
	assign lvl_mid_dec = lvl_mid - htsd_pkg::LVL_W'(1);
	assign wr_en       = push && attaching && !popped;
	assign rd_en       = op.alloc && op.leaf && popped && (lvl_mid != '0);

	always_comb begin
		if (push) begin
			top_next = {op.node, 1'b0};
		end else if (attaching && !popped) begin
			top_next = top_set;
		end else begin
			top_next = top_eff;
		end
	end

	htsd_ram #(.WIDTH(htsd_pkg::PEND_W), .DEPTH(htsd_pkg::STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (lvl_eff_dec[htsd_pkg::STK_IDX_W-1:0]),
		.wdata (top_set),
		.re    (rd_en),
		.raddr (lvl_mid_dec[htsd_pkg::STK_IDX_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			top_q     <= '0;
			reload_s1 <= 1'b0;
		end else begin
			level_q   <= lvl_mid + htsd_pkg::LVL_W'(push);
			top_q     <= top_next;
			reload_s1 <= rd_en;
		end
	end

	assign st.full       = (lvl_eff == htsd_pkg::LVL_W'(htsd_pkg::STACK_DEPTH));
	assign st.empty      = (level_q == '0);
	assign st.att_en     = attaching;
	assign st.att_right  = top_eff[0];
	assign st.att_parent = top_eff[htsd_pkg::PEND_W-1:1];

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= htsd_pkg::LVL_W'(htsd_pkg::STACK_DEPTH))
		else $error("pending stack level beyond depth");

	a_reload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		reload_s1 |-> (level_q != '0))
		else $error("stack top reload with empty stack");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !popped) |=> (level_q == $past(lvl_eff) + htsd_pkg::LVL_W'(1)))
		else $error("push did not grow the stack");

endmodule

[rtl/core/huffman_tree_stream_decoder.sv]
// output: a result is loaded into the output register when its byte is transferred
// throughput: one byte per cycle unless a held result stalls, header and code bits
//   alike, set by the node table reading both children from replicated read ports
// reset: header phase, empty tree and stack, no result pending; the node table and
//   stack memories are not cleared and need no sweep after reset
module huffman_tree_stream_decoder (
	input logic        clk,
	input logic        arst_n,
	htsd_in_if.sink    stream,
	htsd_out_if.source result
);

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_SYMBOL,
		PH_DECODE
	} phase_t;

	phase_t                        phase_q;
	phase_t                        phase_eff;
	phase_t                        phase_next;
	logic [htsd_pkg::CNT_W-1:0]    nodes_q;
	logic [htsd_pkg::CNT_W-1:0]    nodes_eff;
	logic [htsd_pkg::CNT_W-1:0]    nodes_last;
	logic                          out_valid_q;
	logic [htsd_pkg::BYTE_W-1:0]   sym_q;
	logic                          kind_q;
	logic                          rdy;
	logic                          accept;
	logic                          is_leaf;
	logic                          hdr_err;
	logic                          alloc;
	logic                          go_root;
	logic                          dec_hit;
	logic                          res_valid;
	logic [htsd_pkg::BYTE_W-1:0]   res_sym;
	htsd_pkg::node_entry_t [1:0]   ent;
	htsd_pkg::node_entry_t         root;
	htsd_pkg::node_entry_t         chosen;
	htsd_pkg::nt_wr_t              nt_wr;
	htsd_pkg::nt_rd_t              nt_rd;
	htsd_pkg::stk_op_t             stk_op;
	htsd_pkg::stk_st_t             stk_st;

	assign rdy          = !out_valid_q || result.ready;
	assign stream.ready = rdy;
	assign accept       = stream.valid && rdy;

	assign phase_eff  = stream.first_of_file ? PH_FLAG : phase_q;
	assign nodes_eff  = stream.first_of_file ? '0 : nodes_q;
	assign nodes_last = nodes_q - htsd_pkg::CNT_W'(1);
	assign is_leaf    = (stream.in_byte == htsd_pkg::CH_ONE);

	assign hdr_err = (phase_eff == PH_FLAG) &&
		((nodes_eff == htsd_pkg::CNT_W'(htsd_pkg::MAX_NODES)) || (!is_leaf && stk_st.full));
	assign alloc   = accept && (phase_eff == PH_FLAG) && !hdr_err;

	assign stk_op.clear = accept && stream.first_of_file;
	assign stk_op.alloc = alloc;
	assign stk_op.leaf  = is_leaf;
	assign stk_op.node  = nodes_eff[htsd_pkg::NODE_W-1:0];

	htsd_pend_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (stk_op),
		.st     (stk_st)
	);

	// code bit walk
	assign chosen  = (stream.in_byte == htsd_pkg::CH_ZERO) ? ent[0] : ent[1];
	assign dec_hit = root.leaf || chosen.leaf;
	assign go_root = (phase_eff != PH_DECODE) || dec_hit;

	always_comb begin
		case (phase_eff)
			PH_FLAG:   phase_next = (alloc && is_leaf) ? PH_SYMBOL : PH_FLAG;
			PH_SYMBOL: phase_next = stk_st.empty ? PH_DECODE : PH_FLAG;
			PH_DECODE: phase_next = PH_DECODE;
			default:   phase_next = PH_FLAG;
		endcase
	end

	assign nt_wr.alloc_en   = alloc;
	assign nt_wr.alloc_leaf = is_leaf;
	assign nt_wr.alloc_node = nodes_eff[htsd_pkg::NODE_W-1:0];
	assign nt_wr.att_en     = stk_st.att_en;
	assign nt_wr.att_right  = stk_st.att_right;
	assign nt_wr.att_parent = stk_st.att_parent;
	assign nt_wr.sym_en     = accept && (phase_eff == PH_SYMBOL);
	assign nt_wr.sym_node   = nodes_last[htsd_pkg::NODE_W-1:0];
	assign nt_wr.sym_val    = stream.in_byte;

	// prefetch both children of the node the walk moves to
	assign nt_rd.en      = accept && (phase_next == PH_DECODE);
	assign nt_rd.addr[0] = go_root ? root.left : chosen.left;
	assign nt_rd.addr[1] = go_root ? root.right : chosen.right;

	htsd_node_table u_table (
		.clk  (clk),
		.wr   (nt_wr),
		.rd   (nt_rd),
		.ent  (ent),
		.root (root)
	);

	assign res_valid = hdr_err || ((phase_eff == PH_DECODE) && dec_hit);
	assign res_sym   = hdr_err ? '0 : (root.leaf ? root.sym : chosen.sym);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLAG;
			nodes_q     <= '0;
			out_valid_q <= 1'b0;
			sym_q       <= '0;
			kind_q      <= htsd_pkg::KIND_SYMBOL;
		end else begin
			if (accept) begin
				phase_q     <= phase_next;
				nodes_q     <= alloc ? (nodes_eff + htsd_pkg::CNT_W'(1)) : nodes_eff;
				out_valid_q <= res_valid;
				if (res_valid) begin
					sym_q  <= res_sym;
					kind_q <= hdr_err ? htsd_pkg::KIND_ERROR : htsd_pkg::KIND_SYMBOL;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid  = out_valid_q;
	assign result.symbol = sym_q;
	assign result.kind   = kind_q;

	a_decode_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DECODE) |-> stk_st.empty)
		else $error("decoding with internal nodes still pending");

	a_symbol_has_node: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYMBOL) |-> (nodes_q != '0))
		else $error("leaf symbol expected with no node allocated");

	a_nodes_range: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= htsd_pkg::CNT_W'(htsd_pkg::MAX_NODES))
		else $error("node count beyond table size");

endmodule
